FILE: hdl/q2m_pkg.sv
package q2m_pkg;

    // default component width: Q1.14 at 16 bits
    localparam int COMP_WIDTH_DEFAULT = 16;

    // load enables for the two stages held inside each matrix entry
    typedef struct packed {
        logic sum_en;
        logic out_en;
    } stage_en_t;

endpackage

FILE: hdl/q2m_entry.sv
module q2m_entry #(
    parameter int COMP_WIDTH = q2m_pkg::COMP_WIDTH_DEFAULT,
    parameter bit DIAG       = 1'b0,
    parameter bit SUB2       = 1'b0
) (
    input  logic                          clk,
    input  q2m_pkg::stage_en_t            en,
    input  logic signed [2*COMP_WIDTH-1:0] prod_a,
    input  logic signed [2*COMP_WIDTH-1:0] prod_b,
    output logic        [COMP_WIDTH-1:0]   entry
);

    localparam int FRAC = COMP_WIDTH - 2;
    localparam int SW   = 2 * COMP_WIDTH + 2;
    localparam int SHW  = SW - (FRAC - 1);

    // sum held with 2F-1 fraction bits: one, and the rounding half
    localparam logic signed [SW-1:0] BASE = DIAG ? (SW'(1) << (2 * FRAC - 1)) : '0;
    localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC - 2);

    localparam logic signed [SHW-1:0] HI = {{(SHW-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}};
    localparam logic signed [SHW-1:0] LO = ~HI;

    logic signed [SW-1:0]     sum_reg;
    logic signed [SW-1:0]     sum_next;
    logic signed [SW-1:0]     ext_a;
    logic signed [SW-1:0]     ext_b;
    logic signed [SHW-1:0]    shifted;
    logic        [COMP_WIDTH-1:0] entry_reg;
    logic        [COMP_WIDTH-1:0] entry_next;

    assign ext_a = SW'(prod_a);
    assign ext_b = SW'(prod_b);

    always_comb
    begin
        if (DIAG)
        begin
            sum_next = BASE - ext_a - ext_b + HALF;
        end
        else if (SUB2)
        begin
            sum_next = ext_a - ext_b + HALF;
        end
        else
        begin
            sum_next = ext_a + ext_b + HALF;
        end
    end

    // arithmetic drop of the low bits is the floor
    assign shifted = sum_reg[SW-1:FRAC-1];

    always_comb
    begin
        if (shifted > HI)
        begin
            entry_next = HI[COMP_WIDTH-1:0];
        end
        else if (shifted < LO)
        begin
            entry_next = LO[COMP_WIDTH-1:0];
        end
        else
        begin
            entry_next = shifted[COMP_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.sum_en)
        begin
            sum_reg <= sum_next;
        end
        if (en.out_en)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

FILE: hdl/quaternion_to_rotation_matrix.sv
// Quaternion (w, x, y, z) in signed fixed point with COMP_WIDTH - 2 fraction bits
// in, the nine entries of the 3x3 rotation matrix out, column-major (mCR is
// column C, row R), rounded to nearest with ties upward and saturated to the
// signed COMP_WIDTH range. Four register stages: input capture, the nine
// products, the signed sums, round and saturate into the output register.
// The input register loads at the accepting edge, and the word then moves
// through the product, sum and output registers. One word is taken every cycle
// while the output side keeps tready high, and each stage fills its own bubble,
// so a stall at the output holds the pipe without losing or repeating a word.
module quaternion_to_rotation_matrix #(
    parameter int COMP_WIDTH = q2m_pkg::COMP_WIDTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,

    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, zero pad to bytes
    input  logic [((4*COMP_WIDTH+7)/8)*8-1:0]        s_axis_tdata,

    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero pad to bytes
    output logic [((9*COMP_WIDTH+7)/8)*8-1:0]        m_axis_tdata
);

    localparam int W     = COMP_WIDTH;
    localparam int OUT_W = ((9*COMP_WIDTH+7)/8)*8;
    localparam int PW    = 2 * W;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic en1, en2, en3, en4;

    logic signed [W-1:0] w_reg, x_reg, y_reg, z_reg;

    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] xy_reg, xz_reg, yz_reg;
    logic signed [PW-1:0] wx_reg, wy_reg, wz_reg;

    q2m_pkg::stage_en_t ent_en;

    logic [W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    // each stage moves when it is empty or the next one moves
    assign en4 = !v4_reg || m_axis_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_axis_tready = en1;

    assign v1_next = en1 ? s_axis_tvalid : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;
    assign v3_next = en3 ? v2_reg : v3_reg;
    assign v4_next = en4 ? v3_reg : v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            w_reg <= s_axis_tdata[0*W +: W];
            x_reg <= s_axis_tdata[1*W +: W];
            y_reg <= s_axis_tdata[2*W +: W];
            z_reg <= s_axis_tdata[3*W +: W];
        end
        if (en2)
        begin
            xx_reg <= PW'(x_reg * x_reg);
            yy_reg <= PW'(y_reg * y_reg);
            zz_reg <= PW'(z_reg * z_reg);
            xy_reg <= PW'(x_reg * y_reg);
            xz_reg <= PW'(x_reg * z_reg);
            yz_reg <= PW'(y_reg * z_reg);
            wx_reg <= PW'(w_reg * x_reg);
            wy_reg <= PW'(w_reg * y_reg);
            wz_reg <= PW'(w_reg * z_reg);
        end
    end

    assign ent_en.sum_en = en3;
    assign ent_en.out_en = en4;

    q2m_entry #(.COMP_WIDTH(W), .DIAG(1'b1), .SUB2(1'b0)) u_m00
    (
        .clk(clk), .en(ent_en), .prod_a(yy_reg), .prod_b(zz_reg), .entry(m00)
    );
    q2m_entry #(.COMP_WIDTH(W), .DIAG(1'b0), .SUB2(1'b0)) u_m01
    (
        .clk(clk), .en(ent_en), .prod_a(xy_reg), .prod_b(wz_reg), .entry(m01)
    );
    q2m_entry #(.COMP_WIDTH(W), .DIAG(1'b0), .SUB2(1'b1)) u_m02
    (
        .clk(clk), .en(ent_en), .prod_a(xz_reg), .prod_b(wy_reg), .entry(m02)
    );
    q2m_entry #(.COMP_WIDTH(W), .DIAG(1'b0), .SUB2(1'b1)) u_m10
    (
        .clk(clk), .en(ent_en), .prod_a(xy_reg), .prod_b(wz_reg), .entry(m10)
    );
    q2m_entry #(.COMP_WIDTH(W), .DIAG(1'b1), .SUB2(1'b0)) u_m11
    (
        .clk(clk), .en(ent_en), .prod_a(xx_reg), .prod_b(zz_reg), .entry(m11)
    );
    q2m_entry #(.COMP_WIDTH(W), .DIAG(1'b0), .SUB2(1'b0)) u_m12
    (
        .clk(clk), .en(ent_en), .prod_a(yz_reg), .prod_b(wx_reg), .entry(m12)
    );
    q2m_entry #(.COMP_WIDTH(W), .DIAG(1'b0), .SUB2(1'b0)) u_m20
    (
        .clk(clk), .en(ent_en), .prod_a(xz_reg), .prod_b(wy_reg), .entry(m20)
    );
    q2m_entry #(.COMP_WIDTH(W), .DIAG(1'b0), .SUB2(1'b1)) u_m21
    (
        .clk(clk), .en(ent_en), .prod_a(yz_reg), .prod_b(wx_reg), .entry(m21)
    );
    q2m_entry #(.COMP_WIDTH(W), .DIAG(1'b1), .SUB2(1'b0)) u_m22
    (
        .clk(clk), .en(ent_en), .prod_a(xx_reg), .prod_b(yy_reg), .entry(m22)
    );

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = OUT_W'({m22, m21, m20, m12, m11, m10, m02, m01, m00});

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CW        = q2m_pkg::COMP_WIDTH_DEFAULT;
    localparam int FRAC      = CW - 2;
    localparam int LIMIT     = 500000;
    localparam int DRAIN     = 16;
    localparam int HOLD_LEN  = 120;
    localparam int PHASE_LEN = 400;

    typedef logic signed [CW-1:0] entry_t;
    // quaternion word: [0] w, [1] x, [2] y, [3] z
    typedef entry_t [3:0] quat_t;
    // matrix word: [0] m00, [1] m01, [2] m02, [3] m10 ... [8] m22
    typedef entry_t [8:0] mat_t;

    typedef struct {
        quat_t q;
        bit    typed;
        mat_t  m;
    } stim_row_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  s_axis_tvalid = 1'b0;
    logic  s_axis_tready;
    quat_t s_axis_tdata = '0;
    logic  m_axis_tvalid;
    logic  m_axis_tready = 1'b0;
    mat_t  m_axis_tdata;

    mat_t      pending_matrices[$];
    stim_row_t directed_rows[$];
    int        errors = 0;
    int        cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_start = 1'b0;
    int        hold_left = 0;

    quaternion_to_rotation_matrix DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // base in units of 2^-F, acc = +/-p1 +/-p2 with 2F fraction bits
    function automatic entry_t round_sat(input longint base, input longint acc);
        longint r;
        longint hi;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        r = ((base <<< (FRAC - 1)) + acc + (longint'(1) <<< (FRAC - 2))) >>> (FRAC - 1);
        if (r > hi)
            r = hi;
        if (r < -hi - 1)
            r = -hi - 1;
        return entry_t'(r);
    endfunction

    function automatic mat_t rotation_of(input quat_t q);
        longint w, x, y, z, one;
        mat_t   m;
        w = longint'($signed(q[0]));
        x = longint'($signed(q[1]));
        y = longint'($signed(q[2]));
        z = longint'($signed(q[3]));
        one = longint'(1) <<< FRAC;
        m[0] = round_sat(one, -y * y - z * z);
        m[1] = round_sat(0, x * y + w * z);
        m[2] = round_sat(0, x * z - w * y);
        m[3] = round_sat(0, x * y - w * z);
        m[4] = round_sat(one, -x * x - z * z);
        m[5] = round_sat(0, y * z + w * x);
        m[6] = round_sat(0, x * z + w * y);
        m[7] = round_sat(0, y * z - w * x);
        m[8] = round_sat(one, -x * x - y * y);
        return m;
    endfunction

    function automatic quat_t quat(input int w, input int x, input int y, input int z);
        quat_t q;
        q[0] = entry_t'(w);
        q[1] = entry_t'(x);
        q[2] = entry_t'(y);
        q[3] = entry_t'(z);
        return q;
    endfunction

    function automatic mat_t mat9(input int a, input int b, input int c,
                                  input int d, input int e, input int f,
                                  input int g, input int h, input int i);
        mat_t m;
        m[0] = entry_t'(a); m[1] = entry_t'(b); m[2] = entry_t'(c);
        m[3] = entry_t'(d); m[4] = entry_t'(e); m[5] = entry_t'(f);
        m[6] = entry_t'(g); m[7] = entry_t'(h); m[8] = entry_t'(i);
        return m;
    endfunction

    task automatic add_row(input quat_t q, input bit typed, input mat_t m);
        stim_row_t r;
        r.q = q;
        r.typed = typed;
        r.m = m;
        directed_rows.push_back(r);
    endtask

    function automatic quat_t random_quaternion();
        quat_t q;
        int    kind;
        kind = $urandom_range(3);
        for (int k = 0; k < 4; k++)
        begin
            case (kind)
                0:       q[k] = entry_t'($urandom);
                // magnitudes up to 1.0, as unit quaternions have
                1, 2:    q[k] = entry_t'(int'($urandom_range(32768)) - 16384);
                default: q[k] = entry_t'(int'($urandom_range(255)) - 128);
            endcase
        end
        return q;
    endfunction

    // called at an edge; returns at the edge that accepted the word
    task automatic offer(input quat_t q, input mat_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= q;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_matrices.push_back(want);
    endtask

    task automatic take_matrix(input mat_t got);
        mat_t want;
        if (pending_matrices.size() == 0)
        begin
            errors++;
            $display("%0t: word with none expected, got %h", $time, got);
            return;
        end
        want = pending_matrices.pop_front();
        for (int i = 0; i < 9; i++)
        begin
            if (got[i] !== want[i])
            begin
                errors++;
                $display("%0t: m%0d%0d expected %0d, got %0d",
                         $time, i / 3, i % 3, want[i], got[i]);
            end
        end
    endtask

    // output side: check, then decide tready for the next edge
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            take_matrix(m_axis_tdata);
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_start)
        begin
            hold_start = 1'b0;
            hold_left = HOLD_LEN;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        mat_t unit_m;
        int   idle_tab [4];
        int   stall_tab [4];

        unit_m = mat9(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
        idle_tab  = '{0, 74, 0, 15};
        stall_tab = '{0, 0, 74, 15};

        add_row(quat(0, 0, 0, 0), 1'b1, unit_m);
        add_row(quat(16384, 0, 0, 0), 1'b1, unit_m);
        add_row(quat(-16384, 0, 0, 0), 1'b1, unit_m);
        add_row(quat(-32768, 0, 0, 0), 1'b1, unit_m);
        // half turn about x
        add_row(quat(0, 16384, 0, 0), 1'b1,
                mat9(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        // every sum saturates one way or cancels
        add_row(quat(-32768, -32768, -32768, -32768), 1'b1,
                mat9(-32768, 32767, 0, 0, -32768, 32767, 32767, 0, -32768));
        add_row(quat(0, 0, 16384, 0), 1'b0, '0);
        add_row(quat(0, 0, 0, 16384), 1'b0, '0);
        add_row(quat(32767, 32767, 32767, 32767), 1'b0, '0);
        add_row(quat(32767, -32768, 32767, -32768), 1'b0, '0);
        add_row(quat(0, -32768, 0, 0), 1'b0, '0);
        add_row(quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa), 1'b0, '0);
        add_row(quat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555), 1'b0, '0);
        // rounding ties, positive and negative
        add_row(quat(0, 64, 64, 0), 1'b0, '0);
        add_row(quat(0, 64, -64, 0), 1'b0, '0);
        add_row(quat(64, 0, 0, -64), 1'b0, '0);
        add_row(quat(1, 1, 1, 1), 1'b0, '0);
        add_row(quat(-1, -1, -1, -1), 1'b0, '0);
        // quarter turn about z
        add_row(quat(11585, 0, 0, 11585), 1'b0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            offer(directed_rows[r].q,
                  directed_rows[r].typed ? directed_rows[r].m : rotation_of(directed_rows[r].q));

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                quat_t q;
                q = random_quaternion();
                offer(q, rotation_of(q));
            end
        end

        // long hold at the output while words keep coming, so the pipe backs up
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_start = 1'b1;
        for (int n = 0; n < 40; n++)
        begin
            quat_t q;
            q = random_quaternion();
            offer(q, rotation_of(q));
        end

        // let the pipe run dry before the last burst
        s_axis_tvalid <= 1'b0;
        while (pending_matrices.size() != 0)
            @(posedge clk);
        for (int n = 0; n < 20; n++)
        begin
            quat_t q;
            q = random_quaternion();
            offer(q, rotation_of(q));
        end

        s_axis_tvalid <= 1'b0;
        while (pending_matrices.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
